>>> src/s3cim_pkg.sv
package s3cim_pkg;

    localparam int COORD_W = 32;
    localparam int REL_W   = COORD_W + 1;
    localparam int CHUNK_W = 12;
    localparam int FOUND_W = 13;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_MOVE   = 2'd1,
        OP_ADD    = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_LOOK,
        ST_SWEEP,
        ST_DRAIN,
        ST_PUT,
        ST_DONE
    } state_t;

endpackage

>>> src/s3cim_ram.sv
module s3cim_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/sliding_3d_chunk_index_map.sv
// Channel  Direction  Ports                                           Handshake
// s_       in         op, coord_x, coord_y, coord_z, chunk_id         s_valid / s_ready
// m_       out        found_index, in_window                          m_valid / m_ready
//
// Lookup passes through PREP, LOOK and DONE and raises m_valid once the result is
// loaded; move, add and delete sweep every slot through the table RAM, one read and
// one write-back a cycle (a move skips the read where the source slot lies outside
// the old window), through PREP, SWEEP, DRAIN and DONE, with PUT before DONE for an
// add inside the window. s_ready returns with m_valid, once the result is loaded.
// One item is worked at a time. After reset the table is cleared to empty before s_ready rises.
// A result held by m_ready low holds the block in its final state.
module sliding_3d_chunk_index_map
    import s3cim_pkg::*;
#(
    parameter int EDGE       = 16,
    parameter int MAX_CHUNKS = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic signed [COORD_W-1:0]  s_coord_x,
    input  logic signed [COORD_W-1:0]  s_coord_y,
    input  logic signed [COORD_W-1:0]  s_coord_z,
    input  logic [CHUNK_W-1:0]         s_chunk_id,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [FOUND_W-1:0]  m_found_index,
    output logic                       m_in_window
);

    localparam int SLOTS = EDGE * EDGE * EDGE;
    localparam int SW    = $clog2(SLOTS);
    localparam int AW    = $clog2(EDGE);
    localparam int DW    = AW + 2;
    localparam int SXW   = DW + 1;
    localparam int VW    = $clog2(MAX_CHUNKS) + 1;
    localparam int CW    = (VW > FOUND_W) ? VW : FOUND_W;

    localparam logic signed [REL_W-1:0] EDGE_R = REL_W'(EDGE);
    localparam logic signed [SXW-1:0]   EDGE_X = SXW'(EDGE);
    localparam logic [AW-1:0]           LAST_A = AW'(EDGE - 1);
    localparam logic signed [VW-1:0]    TOP_V  = VW'(MAX_CHUNKS - 1);
    localparam logic [CW-1:0]           TOP_W  = CW'(MAX_CHUNKS - 1);
    localparam logic signed [VW-1:0]    EMPTY_V = '1;

    function automatic logic [SW-1:0] slot_addr(input logic [AW-1:0] a,
                                                input logic [AW-1:0] b,
                                                input logic [AW-1:0] c);
        return SW'(a) * SW'(EDGE * EDGE) + SW'(b) * SW'(EDGE) + SW'(c);
    endfunction

    state_t state_reg, state_next;

    op_t                       op_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [VW-1:0]      ci_reg;
    logic signed [COORD_W-1:0] ox_reg, oy_reg, oz_reg;

    logic                      inside_reg;
    logic                      far_reg;
    logic [AW-1:0]             px_reg, py_reg, pz_reg;
    logic signed [DW-1:0]      dx_reg, dy_reg, dz_reg;

    logic [AW-1:0]             ix_reg, iy_reg, iz_reg;
    logic                      dirx_reg, diry_reg, dirz_reg;

    logic                      pipe_valid_reg;
    logic [SW-1:0]             pipe_addr_reg;
    logic                      pipe_ok_reg;

    logic                      m_valid_reg;
    logic signed [FOUND_W-1:0] m_found_reg;
    logic                      m_inwin_reg;

    // window test
    logic signed [REL_W-1:0] rel_x, rel_y, rel_z;
    logic in_x, in_y, in_z, near_x, near_y, near_z;

    assign rel_x = $signed({cx_reg[COORD_W-1], cx_reg}) - $signed({ox_reg[COORD_W-1], ox_reg});
    assign rel_y = $signed({cy_reg[COORD_W-1], cy_reg}) - $signed({oy_reg[COORD_W-1], oy_reg});
    assign rel_z = $signed({cz_reg[COORD_W-1], cz_reg}) - $signed({oz_reg[COORD_W-1], oz_reg});

    assign in_x   = !rel_x[REL_W-1] && (rel_x < EDGE_R);
    assign in_y   = !rel_y[REL_W-1] && (rel_y < EDGE_R);
    assign in_z   = !rel_z[REL_W-1] && (rel_z < EDGE_R);
    assign near_x = (rel_x < EDGE_R) && (rel_x > -EDGE_R);
    assign near_y = (rel_y < EDGE_R) && (rel_y > -EDGE_R);
    assign near_z = (rel_z < EDGE_R) && (rel_z > -EDGE_R);

    // chunk index clamp
    logic [CW-1:0]        cid_w;
    logic signed [VW-1:0] ci_clamped;

    assign cid_w      = CW'(s_chunk_id);
    assign ci_clamped = (cid_w > TOP_W) ? TOP_V : VW'(cid_w);

    // slot iterator
    logic end_x, end_y, end_z, iter_last;
    logic [AW-1:0] ix_step, iy_step, iz_step;

    assign end_x     = dirx_reg ? (ix_reg == '0) : (ix_reg == LAST_A);
    assign end_y     = diry_reg ? (iy_reg == '0) : (iy_reg == LAST_A);
    assign end_z     = dirz_reg ? (iz_reg == '0) : (iz_reg == LAST_A);
    assign iter_last = end_x && end_y && end_z;

    always_comb begin
        iz_step = end_z ? (dirz_reg ? LAST_A : '0)
                        : (dirz_reg ? iz_reg - AW'(1) : iz_reg + AW'(1));
        iy_step = iy_reg;
        ix_step = ix_reg;
        if (end_z) begin
            iy_step = end_y ? (diry_reg ? LAST_A : '0)
                            : (diry_reg ? iy_reg - AW'(1) : iy_reg + AW'(1));
            if (end_y) begin
                ix_step = end_x ? (dirx_reg ? LAST_A : '0)
                                : (dirx_reg ? ix_reg - AW'(1) : ix_reg + AW'(1));
            end
        end
    end

    // source slot of the current sweep step
    logic signed [SXW-1:0] sx, sy, sz;
    logic src_ok;

    assign sx = $signed(SXW'(ix_reg)) + SXW'(dx_reg);
    assign sy = $signed(SXW'(iy_reg)) + SXW'(dy_reg);
    assign sz = $signed(SXW'(iz_reg)) + SXW'(dz_reg);
    assign src_ok = !far_reg
                 && !sx[SXW-1] && (sx < EDGE_X)
                 && !sy[SXW-1] && (sy < EDGE_X)
                 && !sz[SXW-1] && (sz < EDGE_X);

    logic [SW-1:0] iter_addr, src_addr, coord_addr;

    assign iter_addr  = slot_addr(ix_reg, iy_reg, iz_reg);
    assign src_addr   = slot_addr(sx[AW-1:0], sy[AW-1:0], sz[AW-1:0]);
    assign coord_addr = slot_addr(px_reg, py_reg, pz_reg);

    // table RAM
    logic                 ram_we, ram_re;
    logic [SW-1:0]        ram_waddr, ram_raddr;
    logic signed [VW-1:0] ram_wdata, ram_rdata;

    s3cim_ram #(
        .WIDTH (VW),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // write-back value
    logic signed [VW-1:0] mod_value;

    always_comb begin
        mod_value = ram_rdata;
        case (op_reg)
            OP_MOVE: begin
                mod_value = pipe_ok_reg ? ram_rdata : EMPTY_V;
            end
            OP_ADD: begin
                if (ram_rdata >= ci_reg && ram_rdata < TOP_V) begin
                    mod_value = ram_rdata + VW'(1);
                end
            end
            OP_DELETE: begin
                if (ram_rdata == ci_reg) begin
                    mod_value = EMPTY_V;
                end else if (ram_rdata > ci_reg) begin
                    mod_value = ram_rdata - VW'(1);
                end
            end
            default: begin
                mod_value = ram_rdata;
            end
        endcase
    end

    logic signed [CW-1:0]      found_w;
    logic signed [FOUND_W-1:0] found_value;

    assign found_w     = CW'(ram_rdata);
    assign found_value = (op_reg == OP_LOOKUP && inside_reg) ? found_w[FOUND_W-1:0] : '1;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (iter_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = (op_reg == OP_LOOKUP) ? ST_LOOK : ST_SWEEP;
            end
            ST_LOOK: begin
                state_next = ST_DONE;
            end
            ST_SWEEP: begin
                if (iter_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = (op_reg == OP_ADD && inside_reg) ? ST_PUT : ST_DONE;
            end
            ST_PUT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    logic iter_adv, out_load;

    always_comb begin
        s_ready   = 1'b0;
        iter_adv  = 1'b0;
        out_load  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = src_addr;
        ram_we    = pipe_valid_reg;
        ram_waddr = pipe_addr_reg;
        ram_wdata = mod_value;
        case (state_reg)
            ST_CLEAR: begin
                iter_adv  = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = iter_addr;
                ram_wdata = EMPTY_V;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOOK: begin
                ram_re    = inside_reg;
                ram_raddr = coord_addr;
            end
            ST_SWEEP: begin
                iter_adv = 1'b1;
                ram_re   = src_ok;
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = coord_addr;
                ram_wdata = ci_reg;
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            ix_reg         <= '0;
            iy_reg         <= '0;
            iz_reg         <= '0;
            dirx_reg       <= 1'b0;
            diry_reg       <= 1'b0;
            dirz_reg       <= 1'b0;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            ox_reg         <= '0;
            oy_reg         <= '0;
            oz_reg         <= '0;
        end else begin
            state_reg      <= state_next;
            pipe_valid_reg <= (state_reg == ST_SWEEP);
            if (state_reg == ST_PREP) begin
                dirx_reg <= (op_reg == OP_MOVE) && rel_x[REL_W-1];
                diry_reg <= (op_reg == OP_MOVE) && rel_y[REL_W-1];
                dirz_reg <= (op_reg == OP_MOVE) && rel_z[REL_W-1];
                ix_reg   <= ((op_reg == OP_MOVE) && rel_x[REL_W-1]) ? LAST_A : '0;
                iy_reg   <= ((op_reg == OP_MOVE) && rel_y[REL_W-1]) ? LAST_A : '0;
                iz_reg   <= ((op_reg == OP_MOVE) && rel_z[REL_W-1]) ? LAST_A : '0;
                if (op_reg == OP_MOVE) begin
                    ox_reg <= cx_reg;
                    oy_reg <= cy_reg;
                    oz_reg <= cz_reg;
                end
            end else if (iter_adv) begin
                ix_reg <= ix_step;
                iy_reg <= iy_step;
                iz_reg <= iz_step;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= op_t'(s_op);
            cx_reg <= s_coord_x;
            cy_reg <= s_coord_y;
            cz_reg <= s_coord_z;
            ci_reg <= ci_clamped;
        end
        if (state_reg == ST_PREP) begin
            inside_reg <= in_x && in_y && in_z;
            far_reg    <= (op_reg == OP_MOVE) && !(near_x && near_y && near_z);
            px_reg     <= rel_x[AW-1:0];
            py_reg     <= rel_y[AW-1:0];
            pz_reg     <= rel_z[AW-1:0];
            dx_reg     <= (op_reg == OP_MOVE) ? rel_x[DW-1:0] : '0;
            dy_reg     <= (op_reg == OP_MOVE) ? rel_y[DW-1:0] : '0;
            dz_reg     <= (op_reg == OP_MOVE) ? rel_z[DW-1:0] : '0;
        end
        pipe_addr_reg <= iter_addr;
        pipe_ok_reg   <= src_ok;
        if (out_load) begin
            m_found_reg <= found_value;
            m_inwin_reg <= inside_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found_index = m_found_reg;
    assign m_in_window   = m_inwin_reg;

endmodule
